/* src/assert_macros.svh */
// Assertion macros included by the modal phase field rotator top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition that implies a consequence at the same edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition that implies a consequence at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/mpfr_pkg.sv */
// Types, constants and saturation helpers for the modal phase field rotator.
package mpfr_pkg;

	localparam int FRAC_BITS_DEF     = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int GUARD             = 8;
	localparam int ATAN_N            = 24;
	localparam int CW                = 16 + GUARD + 3;
	localparam int ZW                = 34;
	localparam int FRONT_LAT         = 7;
	localparam int ROT_FIXED_LAT     = 5;

	localparam logic [14:0] INV_GAIN     = 15'd19898;
	localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;

	localparam logic [1:0] MODE_TT   = 2'd0;
	localparam logic [1:0] MODE_FIVE = 2'd1;

	localparam logic [2:0] REG_MODE_SET       = 3'd0;
	localparam logic [2:0] REG_PLATE_FOCUS_OFF = 3'd1;
	localparam logic [2:0] REG_WAVE_NUMBER    = 3'd2;
	localparam logic [2:0] REG_FOCUS_SCALE    = 3'd3;
	localparam logic [2:0] REG_CONJ_HEIGHT    = 3'd4;
	localparam logic [2:0] REG_DIR_X          = 3'd5;
	localparam logic [2:0] REG_DIR_Y          = 3'd6;

	localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] coef_tip;
		logic signed [31:0] coef_tilt;
		logic signed [31:0] coef_plate;
		logic signed [31:0] coef_astig_a;
		logic signed [31:0] coef_astig_b;
		logic signed [31:0] coef_focus;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_re;
		logic signed [15:0] out_im;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
		logic signed [31:0] opd;
	} mid_item_t;

	typedef struct packed {
		logic [1:0]         mode_set;
		logic               plate_focus_off;
		logic [31:0]        wave_number;
		logic signed [31:0] focus_scale;
		logic signed [31:0] conj_height;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -65'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(65'(a) + 65'(b));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(65'(a) - 65'(b));
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
		return sat32(-65'(a));
	endfunction

endpackage

/* src/mpfr_fifo.sv */
// Small register-based queue with write, read and empty flag.
module mpfr_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q[AW-1:0]] <= wdata;
	end

	assign rdata = mem_q[rd_ptr_q[AW-1:0]];
	assign empty = (wr_ptr_q == rd_ptr_q);
endmodule

/* src/mpfr_opd.sv */
// Front pipeline: forms the modal optical path difference of each sample.
module mpfr_opd #(
	parameter int FRAC_BITS = mpfr_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mpfr_pkg::cfg_t      cfg,
	input  logic                in_valid,
	input  mpfr_pkg::in_item_t  item,
	output logic                out_valid,
	output mpfr_pkg::mid_item_t out_item
);
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return mpfr_pkg::sat32($signed({p[63], p}) >>> FRAC_BITS);
	endfunction

	localparam logic signed [64:0] ONE_Q = 65'sd1 <<< FRAC_BITS;

	logic [mpfr_pkg::FRONT_LAT-1:0] v_q;
	logic [31:0] smp_pipe_q [mpfr_pkg::FRONT_LAT];
	logic signed [31:0] s1_val;

	logic signed [31:0] xc0_s1, yc1_s1, x2_s1, y2_s1, xy_s1;
	logic signed [31:0] txx_s1, tyy_s1, tyx_s1, txy_s1, sh_s1, s1_s1, c2s1_s1;
	logic signed [31:0] c2_s1, c3_s1, c4_s1, c5_s1;
	logic signed [31:0] acc0_s2, sh_s2, sh2_s2, s1_s2, focus_s2, sxy_s2, dxy_s2;
	logic signed [31:0] xy_s2, sa_s2, sd_s2, sb_s2, c2_s2, c3_s2, c4_s2;
	logic signed [31:0] acc0_s3, mf_s3, ma_s3, mb1_s3, mb2_s3, mc1_s3, mc2_s3;
	logic signed [31:0] c2_s3, c3_s3, c4_s3;
	logic signed [31:0] acc0_s4, acc1_s4, ta_s4, tb_s4, tc_s4, c2_s4, c3_s4, c4_s4;
	logic signed [31:0] acc0_s5, acc1_s5, qa_s5, qb_s5, qc_s5;
	logic signed [31:0] acc0_s6, acc3_s6, qc_s6;
	logic signed [31:0] opd_s7;

	assign s1_val = mpfr_pkg::sat32(ONE_Q - 65'(cfg.focus_scale));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[mpfr_pkg::FRONT_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		smp_pipe_q[0] <= {item.sample_re, item.sample_im};
		for (int i = 1; i < mpfr_pkg::FRONT_LAT; i++)
			smp_pipe_q[i] <= smp_pipe_q[i-1];

		// products of coordinates, coefficients and directions
		xc0_s1  <= qmul(item.x_coord, item.coef_tip);
		yc1_s1  <= qmul(item.y_coord, item.coef_tilt);
		x2_s1   <= qmul(item.x_coord, item.x_coord);
		y2_s1   <= qmul(item.y_coord, item.y_coord);
		xy_s1   <= qmul(item.x_coord, item.y_coord);
		txx_s1  <= qmul(cfg.dir_x, item.x_coord);
		tyy_s1  <= qmul(cfg.dir_y, item.y_coord);
		tyx_s1  <= qmul(cfg.dir_y, item.x_coord);
		txy_s1  <= qmul(cfg.dir_x, item.y_coord);
		sh_s1   <= qmul(cfg.focus_scale, cfg.conj_height);
		s1_s1   <= s1_val;
		c2s1_s1 <= qmul(item.coef_plate, s1_val);
		c2_s1   <= item.coef_plate;
		c3_s1   <= item.coef_astig_a;
		c4_s1   <= item.coef_astig_b;
		c5_s1   <= item.coef_focus;

		acc0_s2 <= mpfr_pkg::qadd(xc0_s1, yc1_s1);
		sh_s2   <= sh_s1;
		sh2_s2  <= mpfr_pkg::qadd(sh_s1, sh_s1);
		s1_s2   <= s1_s1;
		if (cfg.mode_set == mpfr_pkg::MODE_FIVE)
			focus_s2 <= c2s1_s1;
		else if (cfg.plate_focus_off)
			focus_s2 <= c5_s1;
		else
			focus_s2 <= mpfr_pkg::qadd(c5_s1, c2s1_s1);
		sxy_s2  <= mpfr_pkg::qadd(x2_s1, y2_s1);
		dxy_s2  <= mpfr_pkg::qsub(x2_s1, y2_s1);
		xy_s2   <= xy_s1;
		sa_s2   <= mpfr_pkg::qadd(txx_s1, tyy_s1);
		sd_s2   <= mpfr_pkg::qsub(txx_s1, tyy_s1);
		sb_s2   <= mpfr_pkg::qadd(tyx_s1, txy_s1);
		c2_s2   <= c2_s1;
		c3_s2   <= c3_s1;
		c4_s2   <= c4_s1;

		acc0_s3 <= acc0_s2;
		mf_s3   <= qmul(focus_s2, sxy_s2);
		ma_s3   <= qmul(sh2_s2, sa_s2);
		mb1_s3  <= qmul(dxy_s2, s1_s2);
		mb2_s3  <= qmul(sh2_s2, sd_s2);
		mc1_s3  <= qmul(xy_s2, s1_s2);
		mc2_s3  <= qmul(sh_s2, sb_s2);
		c2_s3   <= c2_s2;
		c3_s3   <= c3_s2;
		c4_s3   <= c4_s2;

		acc0_s4 <= acc0_s3;
		acc1_s4 <= mpfr_pkg::qadd(acc0_s3, mf_s3);
		ta_s4   <= mpfr_pkg::qneg(ma_s3);
		tb_s4   <= mpfr_pkg::qsub(mb1_s3, mb2_s3);
		tc_s4   <= mpfr_pkg::qsub(mc1_s3, mc2_s3);
		c2_s4   <= c2_s3;
		c3_s4   <= c3_s3;
		c4_s4   <= c4_s3;

		acc0_s5 <= acc0_s4;
		acc1_s5 <= acc1_s4;
		qa_s5   <= qmul(c2_s4, ta_s4);
		qb_s5   <= qmul(c3_s4, tb_s4);
		qc_s5   <= qmul(c4_s4, tc_s4);

		// accumulate in model order, saturating each partial sum
		acc0_s6 <= acc0_s5;
		acc3_s6 <= mpfr_pkg::qadd(mpfr_pkg::qadd(acc1_s5, qa_s5), qb_s5);
		qc_s6   <= qc_s5;

		if (cfg.mode_set == mpfr_pkg::MODE_TT)
			opd_s7 <= acc0_s6;
		else
			opd_s7 <= mpfr_pkg::qadd(acc3_s6, qc_s6);
	end

	assign out_valid          = v_q[mpfr_pkg::FRONT_LAT-1];
	assign out_item.sample_re = smp_pipe_q[mpfr_pkg::FRONT_LAT-1][31:16];
	assign out_item.sample_im = smp_pipe_q[mpfr_pkg::FRONT_LAT-1][15:0];
	assign out_item.opd       = opd_s7;
endmodule

/* src/mpfr_rot.sv */
// Back pipeline: phase from path difference, turn reduction and CORDIC rotation.
module mpfr_rot #(
	parameter int FRAC_BITS     = mpfr_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = mpfr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         wave_number,
	input  logic                in_valid,
	input  mpfr_pkg::mid_item_t in_item,
	output logic                out_valid,
	output mpfr_pkg::out_item_t out_item
);
	localparam int LAT = CORDIC_STAGES + mpfr_pkg::ROT_FIXED_LAT;
	localparam int SH  = 32 + 2 * FRAC_BITS;
	localparam int CW  = mpfr_pkg::CW;
	localparam int ZW  = mpfr_pkg::ZW;
	localparam int GW  = CW + 16;
	localparam logic signed [GW:0] HALF = (GW+1)'(1) <<< (14 + mpfr_pkg::GUARD);

	function automatic logic signed [15:0] to_q15(input logic signed [GW-1:0] g);
		logic signed [GW:0] r;
		r = (GW+1)'(g) + HALF;
		r = r >>> (15 + mpfr_pkg::GUARD);
		if (r > (GW+1)'(32767))
			return 16'sh7FFF;
		else if (r < -(GW+1)'(32768))
			return 16'sh8000;
		else
			return r[15:0];
	endfunction

	logic [LAT-1:0] v_q;

	logic signed [63:0]  p_s1;
	logic [31:0]         smp_s1, smp_s2, smp_s3;
	logic [63:0]         pp00_s2, pp01_s2;
	logic signed [64:0]  pp10_s2, pp11_s2;
	logic [96:0]         lo_s3;
	logic signed [97:0]  hi_s3;
	logic signed [127:0] total;
	logic [31:0]         ang;
	logic                flip;

	logic signed [CW-1:0] cre_pipe_q [CORDIC_STAGES+1];
	logic signed [CW-1:0] cim_pipe_q [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz_pipe_q  [CORDIC_STAGES+1];
	logic signed [GW-1:0] gre_q, gim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	assign total = 128'($signed({31'd0, lo_s3})) + (128'(hi_s3) <<< 32);
	assign ang   = total[SH+31:SH];
	// fold into the half turn around zero
	assign flip  = ang[31] ^ ang[30];

	always_ff @(posedge clk) begin
		p_s1   <= 64'($signed({1'b0, wave_number}) * in_item.opd);
		smp_s1 <= {in_item.sample_re, in_item.sample_im};

		pp00_s2 <= p_s1[31:0] * mpfr_pkg::TURN_PER_RAD[31:0];
		pp01_s2 <= p_s1[31:0] * mpfr_pkg::TURN_PER_RAD[63:32];
		pp10_s2 <= 65'($signed(p_s1[63:32]) * $signed({1'b0, mpfr_pkg::TURN_PER_RAD[31:0]}));
		pp11_s2 <= 65'($signed(p_s1[63:32]) * $signed({1'b0, mpfr_pkg::TURN_PER_RAD[63:32]}));
		smp_s2  <= smp_s1;

		lo_s3  <= 97'(pp00_s2) + (97'(pp01_s2) << 32);
		hi_s3  <= 98'(pp10_s2) + (98'(pp11_s2) <<< 32);
		smp_s3 <= smp_s2;

		if (flip) begin
			cre_pipe_q[0] <= -(CW'($signed(smp_s3[31:16])) <<< mpfr_pkg::GUARD);
			cim_pipe_q[0] <= -(CW'($signed(smp_s3[15:0])) <<< mpfr_pkg::GUARD);
		end else begin
			cre_pipe_q[0] <= CW'($signed(smp_s3[31:16])) <<< mpfr_pkg::GUARD;
			cim_pipe_q[0] <= CW'($signed(smp_s3[15:0])) <<< mpfr_pkg::GUARD;
		end
		cz_pipe_q[0] <= ZW'($signed({ang[31] ^ flip, ang[30:0]}));

		gre_q <= GW'(cre_pipe_q[CORDIC_STAGES] * $signed({1'b0, mpfr_pkg::INV_GAIN}));
		gim_q <= GW'(cim_pipe_q[CORDIC_STAGES] * $signed({1'b0, mpfr_pkg::INV_GAIN}));
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] AT = ZW'(mpfr_pkg::ATAN_TURNS[i]);
		always_ff @(posedge clk) begin
			if (!cz_pipe_q[i][ZW-1]) begin
				cre_pipe_q[i+1] <= cre_pipe_q[i] - (cim_pipe_q[i] >>> i);
				cim_pipe_q[i+1] <= cim_pipe_q[i] + (cre_pipe_q[i] >>> i);
				cz_pipe_q[i+1]  <= cz_pipe_q[i] - AT;
			end else begin
				cre_pipe_q[i+1] <= cre_pipe_q[i] + (cim_pipe_q[i] >>> i);
				cim_pipe_q[i+1] <= cim_pipe_q[i] - (cre_pipe_q[i] >>> i);
				cz_pipe_q[i+1]  <= cz_pipe_q[i] + AT;
			end
		end
	end

	assign out_valid       = v_q[LAT-1];
	assign out_item.out_re = to_q15(gre_q);
	assign out_item.out_im = to_q15(gim_q);
endmodule

/* src/modal_phase_field_rotator_top.sv */
// Modal phase field rotator: OPD front end, phase queue and CORDIC back end.
// Takes one field sample per clock while full is low and returns one
// rotated sample per clock while results are popped. An item goes through
// the path-difference pipeline, a 16-entry queue, then phase multiply, turn
// reduction, CORDIC rotation and gain correction before it reaches the
// result queue. full rises only when the front queue has no room left for
// items already in flight; the back end issues only while the result queue
// has room, so a stalled pop holds the back end and, later, the front.
// Write configuration only while the block is empty.
module modal_phase_field_rotator_top #(
	parameter int FRAC_BITS     = mpfr_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = mpfr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mpfr_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output mpfr_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_data
);
	`include "assert_macros.svh"

	localparam int MID_DEPTH = 1 << $clog2(mpfr_pkg::FRONT_LAT + 2);
	localparam int OUT_DEPTH = 1 << $clog2(CORDIC_STAGES + mpfr_pkg::ROT_FIXED_LAT + 1);
	localparam int MCW = $clog2(MID_DEPTH) + 1;
	localparam int OCW = $clog2(OUT_DEPTH) + 1;
	localparam int MW  = $bits(mpfr_pkg::mid_item_t);
	localparam int OW  = $bits(mpfr_pkg::out_item_t);

	mpfr_pkg::cfg_t      cfg_q;
	mpfr_pkg::mid_item_t front_item, mid_item;
	mpfr_pkg::out_item_t back_item;
	logic                front_valid, back_valid, mid_empty;
	logic                push_ok, pop_ok, issue;
	logic [MCW-1:0]      fcnt_q;
	logic [OCW-1:0]      bcnt_q;

	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign full    = (fcnt_q == MCW'(MID_DEPTH));
	assign issue   = ~mid_empty & (bcnt_q != OCW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			fcnt_q <= '0;
			bcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					mpfr_pkg::REG_MODE_SET:        cfg_q.mode_set        <= cfg_data[1:0];
					mpfr_pkg::REG_PLATE_FOCUS_OFF: cfg_q.plate_focus_off <= cfg_data[0];
					mpfr_pkg::REG_WAVE_NUMBER:     cfg_q.wave_number     <= cfg_data;
					mpfr_pkg::REG_FOCUS_SCALE:     cfg_q.focus_scale     <= cfg_data;
					mpfr_pkg::REG_CONJ_HEIGHT:     cfg_q.conj_height     <= cfg_data;
					mpfr_pkg::REG_DIR_X:           cfg_q.dir_x           <= cfg_data;
					mpfr_pkg::REG_DIR_Y:           cfg_q.dir_y           <= cfg_data;
					default: ;
				endcase
			end
			// credits: items in the front pipe plus entries held in the mid queue
			if (push_ok && !issue)
				fcnt_q <= fcnt_q + MCW'(1);
			else if (!push_ok && issue)
				fcnt_q <= fcnt_q - MCW'(1);
			if (issue && !pop_ok)
				bcnt_q <= bcnt_q + OCW'(1);
			else if (!issue && pop_ok)
				bcnt_q <= bcnt_q - OCW'(1);
		end
	end

	mpfr_opd #(
		.FRAC_BITS(FRAC_BITS)
	) u_opd (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (push_ok),
		.item     (item),
		.out_valid(front_valid),
		.out_item (front_item)
	);

	mpfr_fifo #(
		.WIDTH(MW),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (front_valid),
		.wdata (front_item),
		.rd    (issue),
		.rdata (mid_item),
		.empty (mid_empty)
	);

	mpfr_rot #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.wave_number(cfg_q.wave_number),
		.in_valid   (issue),
		.in_item    (mid_item),
		.out_valid  (back_valid),
		.out_item   (back_item)
	);

	mpfr_fifo #(
		.WIDTH(OW),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (back_valid),
		.wdata (back_item),
		.rd    (pop_ok),
		.rdata (result),
		.empty (empty)
	);

	`ASSERT_ALWAYS(a_fcnt_bound, clk, arst_n, fcnt_q <= MCW'(MID_DEPTH))
	`ASSERT_ALWAYS(a_bcnt_bound, clk, arst_n, bcnt_q <= OCW'(OUT_DEPTH))
	`ASSERT_IMPLY(a_mid_credit, clk, arst_n, !mid_empty, fcnt_q != '0)
	`ASSERT_IMPLY(a_out_credit, clk, arst_n, !empty, bcnt_q != '0)
	`ASSERT_NEXT(a_push_credit, clk, arst_n, push_ok, fcnt_q != '0)
endmodule
